/* hdl/sdo_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdo_pkg
// Shared types, codes and constants of the expedited SDO server.
// ----------------------------------------------------------------------------
package sdo_pkg;

   localparam int DEF_NODES   = 4;
   localparam int DEF_ENTRIES = 16;

   localparam logic [10:0] ID_RX_LO  = 11'h601;
   localparam logic [10:0] ID_RX_HI  = 11'h67F;
   localparam logic [10:0] ID_RX_BAS = 11'h600;
   localparam logic [10:0] ID_TX_BAS = 11'h580;

   localparam logic [7:0] CMD_READ  = 8'h40;
   localparam logic [7:0] CMD_WR32  = 8'h23;
   localparam logic [7:0] CMD_WR16  = 8'h2B;
   localparam logic [7:0] CMD_WR8   = 8'h2F;
   localparam logic [7:0] RSP_WACK  = 8'h60;
   localparam logic [7:0] RSP_RD32  = 8'h43;
   localparam logic [7:0] RSP_RD16  = 8'h4B;
   localparam logic [7:0] RSP_RD8   = 8'h4F;

   localparam logic [2:0] CSR_ENABLE = 3'd0;
   localparam logic [2:0] CSR_NODE0  = 3'd1;
   localparam logic [2:0] CSR_NODE3  = 3'd4;

   typedef enum logic [2:0] {
      ST_WACK    = 3'd0,
      ST_RD_OK   = 3'd1,
      ST_RD_MISS = 3'd2,
      ST_NOT_RX  = 3'd3,
      ST_OTHER   = 3'd4,
      ST_UNKNOWN = 3'd5,
      ST_LOADED  = 3'd6
   } status_type;

   // entry: valid, index, subindex, class, locked, value
   typedef struct packed {
      logic        valid;
      logic [15:0] index;
      logic [7:0]  subindex;
      logic [1:0]  cls;
      logic        locked;
      logic [31:0] value;
   } entry_type;

   typedef struct packed {
      logic       clear;      // mask data to class width, set class to 32 for reads
      logic       scan;       // read and compare entry at cursor
      logic       next_cls;   // advance class, reset cursor
      logic       store;      // write matching entry at cursor
      logic       do_load;    // write load entry
      logic       finish;     // emit result
   } cmd_type;

   typedef struct packed {
      logic       is_write;
      logic       is_read;
      logic       last_entry;
      logic       last_cls;
      logic       hit;
   } sts_type;

   function automatic logic [31:0] class_mask(input logic [1:0] c);
      unique case (c)
         2'd0:    class_mask = 32'hFFFF_FFFF;
         2'd1:    class_mask = 32'h0000_FFFF;
         default: class_mask = 32'h0000_00FF;
      endcase
   endfunction

endpackage

/* hdl/sdo_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdo_ram
// Generic simple dual-port RAM (one write, one read port) with registered read.
// ----------------------------------------------------------------------------
module sdo_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end
endmodule

/* hdl/sdo_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdo_datapath
// Frame decode, table storage, entry search and result formation.
// ----------------------------------------------------------------------------
module sdo_datapath #(
   parameter int NODES   = sdo_pkg::DEF_NODES,
   parameter int ENTRIES = sdo_pkg::DEF_ENTRIES
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start_beat,
   input  sdo_pkg::cmd_type     cmd,
   output sdo_pkg::sts_type     sts,
   output logic                 direct,
   input  logic                 sdo_enable,
   input  logic [3:0][6:0]      node_ids,
   input  logic                 req_op,
   input  logic [10:0]          req_frame_id,
   input  logic [63:0]          req_frame_bytes,
   input  logic [1:0]           req_load_node,
   input  logic [3:0]           req_load_slot,
   input  logic [15:0]          req_load_index,
   input  logic [7:0]           req_load_subindex,
   input  logic [1:0]           req_load_class,
   input  logic                 req_load_locked,
   input  logic [31:0]          req_load_value,
   output logic [2:0]           rsp_status,
   output logic                 rsp_reply_valid,
   output logic [10:0]          rsp_reply_id,
   output logic [3:0]           rsp_reply_len,
   output logic [63:0]          rsp_reply_bytes,
   output logic [15:0]          rsp_req_index,
   output logic [7:0]           rsp_req_subindex,
   output logic [6:0]           rsp_req_node
);
   localparam int DEPTH = NODES * ENTRIES;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int EW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int NW    = (NODES > 1) ? $clog2(NODES) : 1;
   localparam int VW    = $bits(sdo_pkg::entry_type) - 1;

   // valid bits in flip-flops, payload in RAM
   logic [DEPTH-1:0] valid_ff, valid_in;

   logic [NW-1:0]  slot_ff, slot_in;
   logic [6:0]     nid_ff, nid_in;
   logic [7:0]     ccmd_ff, ccmd_in;
   logic [15:0]    idx_ff, idx_in;
   logic [7:0]     sub_ff, sub_in;
   logic [31:0]    data_ff, data_in;
   logic [1:0]     cls_ff, cls_in;
   logic [EW:0]    cur_ff, cur_in;
   logic [EW-1:0]  rd_cur_ff, rd_cur_in;
   logic           hit_ff, hit_in;
   logic [31:0]    hval_ff, hval_in;
   logic           pend_ff, pend_in;

   logic [2:0]  st_ff, st_in;
   logic        rv_ff, rv_in;
   logic [10:0] rid_ff, rid_in;
   logic [3:0]  rlen_ff, rlen_in;
   logic [63:0] rb_ff, rb_in;
   logic [15:0] ridx_ff, ridx_in;
   logic [7:0]  rsub_ff, rsub_in;
   logic [6:0]  rnode_ff, rnode_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [VW-1:0] wr_data, rd_data;
   sdo_pkg::entry_type ent;

   logic [NW-1:0] m_slot;
   logic          m_any;
   logic          in_rng;
   logic          load_ok;
   logic [AW-1:0] load_addr;
   logic          match;

   sdo_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_comb begin
      m_slot = '0;
      m_any  = 1'b0;
      for (int n = NODES - 1; n >= 0; n--) begin
         if (req_frame_id == sdo_pkg::ID_RX_BAS + {4'd0, node_ids[n]}) begin
            m_slot = NW'(n);
            m_any  = 1'b1;
         end
      end
      in_rng  = (req_frame_id >= sdo_pkg::ID_RX_LO) && (req_frame_id <= sdo_pkg::ID_RX_HI);
      load_ok = (32'(req_load_node) < NODES) && (32'(req_load_slot) < ENTRIES)
                && (req_load_class != 2'd3);
      load_addr = AW'(32'(req_load_node) * ENTRIES + 32'(req_load_slot));
   end

   assign ent   = {valid_ff[AW'(32'(slot_ff) * ENTRIES + 32'(rd_cur_ff))], rd_data};
   assign match = ent.valid && !ent.locked && ent.cls == cls_ff
                  && ent.index == idx_ff && ent.subindex == sub_ff && pend_ff;

   // direct result when no table search is needed
   assign direct = req_op || !sdo_enable || !in_rng || !m_any;

   assign rd_addr = AW'(32'(slot_ff) * ENTRIES + 32'(cur_ff[EW-1:0]));

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = AW'(32'(slot_ff) * ENTRIES + 32'(rd_cur_ff));
      wr_data = {idx_ff, sub_ff, cls_ff, 1'b0, data_ff};
      if (cmd.do_load) begin
         wr_en   = req_op && load_ok;
         wr_addr = load_addr;
         wr_data = {req_load_index, req_load_subindex, req_load_class, req_load_locked,
                    req_load_value & sdo_pkg::class_mask(req_load_class)};
      end else if (cmd.store && match) begin
         wr_en = 1'b1;
      end
   end

   always_comb begin
      valid_in  = valid_ff;
      slot_in   = slot_ff;
      nid_in    = nid_ff;
      ccmd_in   = ccmd_ff;
      idx_in    = idx_ff;
      sub_in    = sub_ff;
      data_in   = data_ff;
      cls_in    = cls_ff;
      cur_in    = cur_ff;
      rd_cur_in = rd_cur_ff;
      hit_in    = hit_ff;
      hval_in   = hval_ff;
      pend_in   = 1'b0;
      st_in     = st_ff;
      rv_in     = rv_ff;
      rid_in    = rid_ff;
      rlen_in   = rlen_ff;
      rb_in     = rb_ff;
      ridx_in   = ridx_ff;
      rsub_in   = rsub_ff;
      rnode_in  = rnode_ff;
      if (start_beat) begin
         slot_in  = m_slot;
         nid_in   = node_ids[m_slot];
         ccmd_in  = req_frame_bytes[7:0];
         idx_in   = req_frame_bytes[23:8];
         sub_in   = req_frame_bytes[31:24];
         data_in  = req_frame_bytes[63:32];
         cls_in   = (req_frame_bytes[7:0] == sdo_pkg::CMD_WR16) ? 2'd1 :
                    (req_frame_bytes[7:0] == sdo_pkg::CMD_WR8) ? 2'd2 : 2'd0;
         cur_in   = '0;
         hit_in   = 1'b0;
         st_in    = sdo_pkg::ST_UNKNOWN;
         rv_in    = 1'b0;
         rid_in   = '0;
         rlen_in  = '0;
         rb_in    = '0;
         ridx_in  = '0;
         rsub_in  = '0;
         rnode_in = '0;
         priority if (req_op) begin
            if (load_ok) begin
               st_in = sdo_pkg::ST_LOADED;
               valid_in[load_addr] = 1'b1;
            end
         end else if (!sdo_enable) begin
         end else if (!in_rng) begin
            st_in = sdo_pkg::ST_NOT_RX;
         end else if (!m_any) begin
            st_in    = sdo_pkg::ST_OTHER;
            rnode_in = 7'(req_frame_id - sdo_pkg::ID_RX_BAS);
         end
      end
      if (cmd.clear) begin
         data_in = data_ff & sdo_pkg::class_mask(cls_ff);
         if (ccmd_ff == sdo_pkg::CMD_READ) cls_in = 2'd0;
      end
      if (cmd.scan) begin
         rd_cur_in = cur_ff[EW-1:0];
         cur_in    = cur_ff + 1'b1;
         pend_in   = 1'b1;
      end
      if (match) begin
         hit_in  = 1'b1;
         hval_in = ent.value;
      end
      if (cmd.next_cls) begin
         cls_in = cls_ff + 2'd1;
         cur_in = '0;
         hit_in = 1'b0;
      end
      if (cmd.finish) begin
         ridx_in  = idx_ff;
         rsub_in  = sub_ff;
         rnode_in = nid_ff;
         if (sts.is_write) begin
            st_in   = sdo_pkg::ST_WACK;
            rv_in   = 1'b1;
            rid_in  = sdo_pkg::ID_TX_BAS + {4'd0, nid_ff};
            rlen_in = 4'd8;
            rb_in   = {32'd0, sub_ff, idx_ff, sdo_pkg::RSP_WACK};
         end else if (sts.is_read && (hit_ff || match)) begin
            st_in   = sdo_pkg::ST_RD_OK;
            rv_in   = 1'b1;
            rid_in  = sdo_pkg::ID_TX_BAS + {4'd0, nid_ff};
            rlen_in = (cls_ff == 2'd0) ? 4'd8 : (cls_ff == 2'd1) ? 4'd6 : 4'd5;
            rb_in   = {(match ? ent.value : hval_ff) & sdo_pkg::class_mask(cls_ff),
                       sub_ff, idx_ff,
                       (cls_ff == 2'd0) ? sdo_pkg::RSP_RD32 :
                       (cls_ff == 2'd1) ? sdo_pkg::RSP_RD16 : sdo_pkg::RSP_RD8};
         end else if (sts.is_read) begin
            st_in = sdo_pkg::ST_RD_MISS;
         end else begin
            st_in = sdo_pkg::ST_UNKNOWN;
         end
      end
   end

   assign sts.is_write   = ccmd_ff == sdo_pkg::CMD_WR32 || ccmd_ff == sdo_pkg::CMD_WR16
                           || ccmd_ff == sdo_pkg::CMD_WR8;
   assign sts.is_read    = ccmd_ff == sdo_pkg::CMD_READ;
   assign sts.last_entry = 32'(cur_ff) >= ENTRIES;
   assign sts.last_cls   = cls_ff == 2'd2;
   assign sts.hit        = hit_ff || match;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         pend_ff  <= 1'b0;
         rv_ff    <= 1'b0;
         rlen_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         pend_ff  <= pend_in;
         rv_ff    <= rv_in;
         rlen_ff  <= rlen_in;
      end
      slot_ff   <= slot_in;
      nid_ff    <= nid_in;
      ccmd_ff   <= ccmd_in;
      idx_ff    <= idx_in;
      sub_ff    <= sub_in;
      data_ff   <= data_in;
      cls_ff    <= cls_in;
      cur_ff    <= cur_in;
      rd_cur_ff <= rd_cur_in;
      hit_ff    <= hit_in;
      hval_ff   <= hval_in;
      st_ff     <= st_in;
      rid_ff    <= rid_in;
      rb_ff     <= rb_in;
      ridx_ff   <= ridx_in;
      rsub_ff   <= rsub_in;
      rnode_ff  <= rnode_in;
   end

   assign rsp_status       = st_ff;
   assign rsp_reply_valid  = rv_ff;
   assign rsp_reply_id     = rid_ff;
   assign rsp_reply_len    = rlen_ff;
   assign rsp_reply_bytes  = rb_ff;
   assign rsp_req_index    = ridx_ff;
   assign rsp_req_subindex = rsub_ff;
   assign rsp_req_node     = rnode_ff;

   ap_no_reply_len: assert property (@(posedge clock) disable iff (reset)
      !rv_ff |-> rlen_ff == 4'd0);
   ap_reply_id: assert property (@(posedge clock) disable iff (reset)
      rv_ff |-> rid_ff == sdo_pkg::ID_TX_BAS + {4'd0, rnode_ff});
   ap_load_valid: assert property (@(posedge clock) disable iff (reset)
      start_beat && req_op && load_ok |=> valid_ff[$past(load_addr)]);
endmodule

/* hdl/sdo_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdo_ctrl
// Sequencer for decode, entry scan per class and result strobe.
// ----------------------------------------------------------------------------
module sdo_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             direct,
   input  sdo_pkg::sts_type sts,
   output sdo_pkg::cmd_type cmd,
   output logic             busy,
   output logic             start_beat,
   output logic             done
);
   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_PREP  = 6'b000010,
      S_SCAN  = 6'b000100,
      S_DRAIN = 6'b001000,
      S_FIN   = 6'b010000,
      S_OUT   = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   assign start_beat = start && state_ff == S_IDLE;
   assign busy       = state_ff != S_IDLE;
   assign done       = state_ff == S_OUT;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.do_load = start_beat;
      unique case (state_ff)
         S_IDLE:  if (start) state_in = direct ? S_OUT : S_PREP;
         S_PREP: begin
            cmd.clear = 1'b1;
            state_in  = (sts.is_write || sts.is_read) ? S_SCAN : S_FIN;
         end
         S_SCAN: begin
            cmd.store = sts.is_write;
            if (sts.last_entry) state_in = S_DRAIN;
            else cmd.scan = 1'b1;
         end
         S_DRAIN: begin
            cmd.store = sts.is_write;
            if (sts.is_read && !sts.hit && !sts.last_cls) begin
               cmd.next_cls = 1'b1;
               state_in     = S_SCAN;
            end else begin
               cmd.finish = 1'b1;
               state_in   = S_OUT;
            end
         end
         S_FIN: begin
            cmd.finish = 1'b1;
            state_in   = S_OUT;
         end
         S_OUT:   state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   ap_done_once: assert property (@(posedge clock) disable iff (reset)
      done |=> !done);
   ap_fin_out: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> done);
   ap_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      start_beat |=> busy);
endmodule

/* hdl/sdo_expedited_server.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdo_expedited_server
// Expedited CANopen SDO server for up to four node ids.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with the request fields; the beat is taken when start is high
//   and busy is low. req_op 1 loads a table entry, 0 presents a received CAN
//   frame. One result appears on the rsp_ ports for exactly one cycle, marked
//   by rsp_valid; the receiver cannot stall.
//   Loads and frames that need no table access give the result in the
//   cycle right after acceptance; an unknown command goes through S_PREP and
//   S_FIN before its result. Writes scan the node's ENTRIES entries once,
//   reads scan once per width class until a hit; the single table read port,
//   one entry a cycle, sets the length of each scan.
//   One item is in flight at a time; busy drops in the cycle after the result.
//   Configuration: csr_we, csr_index, csr_wdata, written while idle.
//   Reset clears the control registers and marks every entry invalid at once.
// ----------------------------------------------------------------------------
module sdo_expedited_server #(
   parameter int NODES   = sdo_pkg::DEF_NODES,
   parameter int ENTRIES = sdo_pkg::DEF_ENTRIES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [6:0]  csr_wdata,
   input  logic        start,
   output logic        busy,
   input  logic        req_op,
   input  logic [10:0] req_frame_id,
   input  logic [63:0] req_frame_bytes,
   input  logic [1:0]  req_load_node,
   input  logic [3:0]  req_load_slot,
   input  logic [15:0] req_load_index,
   input  logic [7:0]  req_load_subindex,
   input  logic [1:0]  req_load_class,
   input  logic        req_load_locked,
   input  logic [31:0] req_load_value,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic        rsp_reply_valid,
   output logic [10:0] rsp_reply_id,
   output logic [3:0]  rsp_reply_len,
   output logic [63:0] rsp_reply_bytes,
   output logic [15:0] rsp_req_index,
   output logic [7:0]  rsp_req_subindex,
   output logic [6:0]  rsp_req_node
);
   logic            en_ff, en_in;
   logic [3:0][6:0] ids_ff, ids_in;
   sdo_pkg::cmd_type cmd;
   sdo_pkg::sts_type sts;
   logic            direct, start_beat;

   always_comb begin
      en_in  = en_ff;
      ids_in = ids_ff;
      if (csr_we) begin
         if (csr_index == sdo_pkg::CSR_ENABLE) en_in = csr_wdata[0];
         else if (csr_index >= sdo_pkg::CSR_NODE0 && csr_index <= sdo_pkg::CSR_NODE3)
            ids_in[2'(csr_index - sdo_pkg::CSR_NODE0)] = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff  <= 1'b0;
         ids_ff <= '0;
      end else begin
         en_ff  <= en_in;
         ids_ff <= ids_in;
      end
   end

   sdo_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .direct(direct), .sts(sts),
      .cmd(cmd), .busy(busy), .start_beat(start_beat), .done(rsp_valid)
   );

   sdo_datapath #(.NODES(NODES), .ENTRIES(ENTRIES)) u_dp (
      .clock(clock), .reset(reset), .start_beat(start_beat), .cmd(cmd), .sts(sts),
      .direct(direct), .sdo_enable(en_ff), .node_ids(ids_ff),
      .req_op(req_op), .req_frame_id(req_frame_id), .req_frame_bytes(req_frame_bytes),
      .req_load_node(req_load_node), .req_load_slot(req_load_slot),
      .req_load_index(req_load_index), .req_load_subindex(req_load_subindex),
      .req_load_class(req_load_class), .req_load_locked(req_load_locked),
      .req_load_value(req_load_value),
      .rsp_status(rsp_status), .rsp_reply_valid(rsp_reply_valid),
      .rsp_reply_id(rsp_reply_id), .rsp_reply_len(rsp_reply_len),
      .rsp_reply_bytes(rsp_reply_bytes), .rsp_req_index(rsp_req_index),
      .rsp_req_subindex(rsp_req_subindex), .rsp_req_node(rsp_req_node)
   );
endmodule
